// ===== src/drae_pkg.sv =====
// Shared types for the DNS response address extractor.
`timescale 1ns / 1ps
package drae_pkg;

    typedef enum logic [3:0] {
        PH_HEADER = 4'd0,
        PH_QNAME  = 4'd1,
        PH_QPTR   = 4'd2,
        PH_QTAIL  = 4'd3,
        PH_ANAME  = 4'd4,
        PH_APTR   = 4'd5,
        PH_AFIXED = 4'd6,
        PH_ADATA  = 4'd7,
        PH_DONE   = 4'd8
    } phase_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NEGATIVE = 2'd1,
        ST_ERROR    = 2'd2
    } status_t;

    localparam logic [15:0] TYPE_A    = 16'd1;
    localparam logic [15:0] TYPE_AAAA = 16'd28;
    localparam logic [3:0]  RCODE_NXDOMAIN = 4'd3;
    localparam logic [31:0] TTL_CAP  = 32'd60;
    localparam logic [31:0] TTL_ZERO_SUB = 32'd30;
    localparam logic [31:0] TTL_NEGATIVE = 32'd5;
    localparam logic [3:0]  DATA_KIND_V4 = 4'd1;
    localparam logic [3:0]  DATA_KIND_V6 = 4'd2;

    typedef struct packed {
        logic        result_kind;
        logic        address_family;
        logic [63:0] address_high;
        logic [63:0] address_low;
        logic [31:0] ttl_value;
        logic [1:0]  parse_status;
        logic [3:0]  address_count;
    } result_t;

endpackage

// ===== src/dns_response_address_extractor_top.sv =====
// Top level of the DNS response address extractor.
`timescale 1ns / 1ps
// The block takes one message byte per cycle and updates its parse state in
// that same cycle, so a byte can be transferred on every clock. A byte that
// completes an address record, is marked last, or both, produces one or two
// results that enter a four-entry output queue; input stall rises only when
// that queue holds more than two results, so the rate is one byte per cycle
// as long as results are drained. Results are registered in the queue.
module dns_response_address_extractor_top #(
    parameter int MAX_ADDRESSES = 8,
    parameter int MAX_LABELS = 128
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  message_byte,
    input  logic        last_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        result_kind,
    output logic        address_family,
    output logic [63:0] address_high,
    output logic [63:0] address_low,
    output logic [31:0] ttl_value,
    output logic [1:0]  parse_status,
    output logic [3:0]  address_count,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data
);
    import drae_pkg::*;

    localparam logic CFG_QUERY_ID = 1'b0;
    localparam logic CFG_WANTED_TYPE = 1'b1;

    logic [15:0] query_id_reg;
    logic [15:0] wanted_type_reg;
    logic        accept;
    logic        addr_push;
    logic        sum_push;
    logic        full2;
    result_t     addr_result;
    result_t     sum_result;
    result_t     out_data;

    assign cfg_ready = 1'b1;
    assign in_stall  = full2;
    assign accept    = in_valid && !full2;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            query_id_reg    <= '0;
            wanted_type_reg <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_QUERY_ID:    query_id_reg <= cfg_data;
                CFG_WANTED_TYPE: wanted_type_reg <= cfg_data;
                default:         query_id_reg <= query_id_reg;
            endcase
        end
    end

    drae_parser #(
        .MAX_ADDRESSES(MAX_ADDRESSES),
        .MAX_LABELS(MAX_LABELS)
    ) u_parser (
        .clk(clk),
        .rst_n(rst_n),
        .accept(accept),
        .message_byte(message_byte),
        .last_byte(last_byte),
        .expected_query_id(query_id_reg),
        .wanted_record_type(wanted_type_reg),
        .addr_push(addr_push),
        .addr_result(addr_result),
        .sum_push(sum_push),
        .sum_result(sum_result)
    );

    drae_out_fifo u_fifo (
        .clk(clk),
        .rst_n(rst_n),
        .push_a(addr_push),
        .data_a(addr_result),
        .push_b(sum_push),
        .data_b(sum_result),
        .full2(full2),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_data(out_data)
    );

    assign result_kind    = out_data.result_kind;
    assign address_family = out_data.address_family;
    assign address_high   = out_data.address_high;
    assign address_low    = out_data.address_low;
    assign ttl_value      = out_data.ttl_value;
    assign parse_status   = out_data.parse_status;
    assign address_count  = out_data.address_count;

endmodule

// ===== src/drae_parser.sv =====
// Byte-wise parser state and result generation for DNS responses.
`timescale 1ns / 1ps
module drae_parser #(
    parameter int MAX_ADDRESSES = 8,
    parameter int MAX_LABELS = 128
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             accept,
    input  logic [7:0]       message_byte,
    input  logic             last_byte,
    input  logic [15:0]      expected_query_id,
    input  logic [15:0]      wanted_record_type,
    output logic             addr_push,
    output drae_pkg::result_t addr_result,
    output logic             sum_push,
    output drae_pkg::result_t sum_result
);
    import drae_pkg::*;

    localparam int FW = $clog2(MAX_ADDRESSES + 1);

    phase_t        phase_reg, phase_next;
    logic [3:0]    idx_reg, idx_next;
    logic [15:0]   q_reg, q_next;
    logic [15:0]   a_reg, a_next;
    logic [5:0]    lbl_reg, lbl_next;
    logic [7:0]    seen_reg, seen_next;
    logic [15:0]   type_reg, type_next;
    logic [31:0]   ttl_reg, ttl_next;
    logic [15:0]   dlen_reg, dlen_next;
    logic [127:0]  shift_reg, shift_next;
    logic [FW-1:0] found_reg, found_next;
    logic [31:0]   low_reg, low_next;
    logic          err_reg, err_next;
    logic          neg_reg, neg_next;

    logic [15:0]  dlen_new;
    logic [15:0]  a_dec;
    logic [15:0]  q_dec;
    logic [3:0]   idx_inc;
    logic [127:0] shift_new;
    logic         match;
    logic [FW-1:0] found_inc;
    logic [31:0]  found_wide;
    logic         in_qname;
    phase_t       ptr_phase;
    phase_t       tail_phase;

    always_comb
    begin
        phase_next = phase_reg;
        idx_next   = idx_reg;
        q_next     = q_reg;
        a_next     = a_reg;
        lbl_next   = lbl_reg;
        seen_next  = seen_reg;
        type_next  = type_reg;
        ttl_next   = ttl_reg;
        dlen_next  = dlen_reg;
        shift_next = shift_reg;
        found_next = found_reg;
        low_next   = low_reg;
        err_next   = err_reg;
        neg_next   = neg_reg;
        addr_push  = 1'b0;
        addr_result = '0;
        sum_push   = 1'b0;
        sum_result = '0;
        dlen_new   = {dlen_reg[7:0], message_byte};
        a_dec      = a_reg - 16'd1;
        q_dec      = q_reg - 16'd1;
        idx_inc    = idx_reg + 4'd1;
        shift_new  = {shift_reg[119:0], message_byte};
        match      = (type_reg == wanted_record_type) || (wanted_record_type == 16'd0);
        found_inc  = found_reg + FW'(1);
        in_qname   = (phase_reg == PH_QNAME);
        ptr_phase  = in_qname ? PH_QPTR : PH_APTR;
        tail_phase = in_qname ? PH_QTAIL : PH_AFIXED;
        found_wide = 32'd0;

        if (accept)
        begin
            case (phase_reg)
                PH_HEADER:
                begin
                    if (idx_reg < 4'd4)
                        ttl_next = {ttl_reg[23:0], message_byte};
                    else if (idx_reg < 4'd6)
                        q_next = {q_reg[7:0], message_byte};
                    else if (idx_reg < 4'd8)
                        a_next = {a_reg[7:0], message_byte};
                    if (idx_reg >= 4'd11)
                    begin
                        if (ttl_reg[31:16] != expected_query_id)
                        begin
                            err_next = 1'b1;
                            phase_next = PH_DONE;
                        end
                        else if (ttl_reg[3:0] == RCODE_NXDOMAIN)
                        begin
                            neg_next = 1'b1;
                            phase_next = PH_DONE;
                        end
                        else if (ttl_reg[3:0] != 4'd0)
                        begin
                            err_next = 1'b1;
                            phase_next = PH_DONE;
                        end
                        else if (q_reg != 16'd0)
                        begin
                            phase_next = PH_QNAME;
                            lbl_next = '0;
                            seen_next = '0;
                            idx_next = '0;
                        end
                        else if (a_reg == 16'd0 || 32'(found_reg) >= MAX_ADDRESSES)
                            phase_next = PH_DONE;
                        else
                        begin
                            phase_next = PH_ANAME;
                            lbl_next = '0;
                            seen_next = '0;
                            idx_next = '0;
                        end
                    end
                    else
                        idx_next = idx_inc;
                end
                PH_QNAME, PH_ANAME:
                begin
                    if (lbl_reg != 6'd0)
                        lbl_next = lbl_reg - 6'd1;
                    else if (message_byte == 8'd0)
                    begin
                        phase_next = tail_phase;
                        idx_next = '0;
                    end
                    else if (message_byte[7:6] == 2'b11)
                        phase_next = ptr_phase;
                    else if (message_byte[7:6] != 2'b00 || 32'(seen_reg) >= MAX_LABELS)
                    begin
                        err_next = 1'b1;
                        phase_next = PH_DONE;
                    end
                    else
                    begin
                        seen_next = seen_reg + 8'd1;
                        lbl_next = message_byte[5:0];
                    end
                end
                PH_QPTR:
                begin
                    phase_next = PH_QTAIL;
                    idx_next = '0;
                end
                PH_APTR:
                begin
                    phase_next = PH_AFIXED;
                    idx_next = '0;
                end
                PH_QTAIL:
                begin
                    idx_next = idx_inc;
                    if (idx_inc >= 4'd4)
                    begin
                        q_next = q_dec;
                        if (q_dec != 16'd0)
                        begin
                            phase_next = PH_QNAME;
                            lbl_next = '0;
                            seen_next = '0;
                            idx_next = '0;
                        end
                        else if (a_reg == 16'd0 || 32'(found_reg) >= MAX_ADDRESSES)
                            phase_next = PH_DONE;
                        else
                        begin
                            phase_next = PH_ANAME;
                            lbl_next = '0;
                            seen_next = '0;
                            idx_next = '0;
                        end
                    end
                end
                PH_AFIXED:
                begin
                    if (idx_reg < 4'd2)
                        type_next = {type_reg[7:0], message_byte};
                    else if (idx_reg >= 4'd4 && idx_reg < 4'd8)
                        ttl_next = {ttl_reg[23:0], message_byte};
                    else if (idx_reg >= 4'd8)
                        dlen_next = dlen_new;
                    if (idx_reg >= 4'd9)
                    begin
                        if (ttl_reg < low_reg)
                            low_next = ttl_reg;
                        idx_next = (dlen_new == 16'd4) ? DATA_KIND_V4 :
                                   (dlen_new == 16'd16) ? DATA_KIND_V6 : 4'd0;
                        shift_next = '0;
                        if (dlen_new == 16'd0)
                        begin
                            a_next = a_dec;
                            if (a_dec == 16'd0 || 32'(found_reg) >= MAX_ADDRESSES)
                                phase_next = PH_DONE;
                            else
                            begin
                                phase_next = PH_ANAME;
                                lbl_next = '0;
                                seen_next = '0;
                                idx_next = '0;
                            end
                        end
                        else
                            phase_next = PH_ADATA;
                    end
                    else
                        idx_next = idx_inc;
                end
                PH_ADATA:
                begin
                    shift_next = shift_new;
                    dlen_next = dlen_reg - 16'd1;
                    if (dlen_reg == 16'd1)
                    begin
                        if (match && type_reg == TYPE_A && idx_reg == DATA_KIND_V4)
                        begin
                            addr_push = 1'b1;
                            addr_result.address_high = {shift_new[31:0], 32'd0};
                            addr_result.ttl_value = ttl_reg;
                            found_next = found_inc;
                        end
                        else if (match && type_reg == TYPE_AAAA && idx_reg == DATA_KIND_V6)
                        begin
                            addr_push = 1'b1;
                            addr_result.address_family = 1'b1;
                            addr_result.address_high = shift_new[127:64];
                            addr_result.address_low = shift_new[63:0];
                            addr_result.ttl_value = ttl_reg;
                            found_next = found_inc;
                        end
                        a_next = a_dec;
                        if (a_dec == 16'd0 || 32'(found_next) >= MAX_ADDRESSES)
                            phase_next = PH_DONE;
                        else
                        begin
                            phase_next = PH_ANAME;
                            lbl_next = '0;
                            seen_next = '0;
                            idx_next = '0;
                        end
                    end
                end
                default:
                begin
                end
            endcase

            if (last_byte)
            begin
                found_wide = 32'(found_next);
                sum_push = 1'b1;
                sum_result.result_kind = 1'b1;
                sum_result.address_count = found_wide[3:0];
                if (phase_next != PH_DONE || err_next)
                begin
                    sum_result.parse_status = ST_ERROR;
                    sum_result.ttl_value = 32'd0;
                end
                else if (neg_next || found_next == '0)
                begin
                    sum_result.parse_status = ST_NEGATIVE;
                    sum_result.ttl_value = TTL_NEGATIVE;
                end
                else
                begin
                    sum_result.parse_status = ST_OK;
                    sum_result.ttl_value = (low_next == 32'd0) ? TTL_ZERO_SUB : low_next;
                end
                phase_next = PH_HEADER;
                idx_next   = '0;
                q_next     = '0;
                a_next     = '0;
                lbl_next   = '0;
                seen_next  = '0;
                type_next  = '0;
                ttl_next   = '0;
                dlen_next  = '0;
                shift_next = '0;
                found_next = '0;
                low_next   = TTL_CAP;
                err_next   = 1'b0;
                neg_next   = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HEADER;
            idx_reg   <= '0;
            q_reg     <= '0;
            a_reg     <= '0;
            lbl_reg   <= '0;
            seen_reg  <= '0;
            type_reg  <= '0;
            ttl_reg   <= '0;
            dlen_reg  <= '0;
            shift_reg <= '0;
            found_reg <= '0;
            low_reg   <= TTL_CAP;
            err_reg   <= 1'b0;
            neg_reg   <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            idx_reg   <= idx_next;
            q_reg     <= q_next;
            a_reg     <= a_next;
            lbl_reg   <= lbl_next;
            seen_reg  <= seen_next;
            type_reg  <= type_next;
            ttl_reg   <= ttl_next;
            dlen_reg  <= dlen_next;
            shift_reg <= shift_next;
            found_reg <= found_next;
            low_reg   <= low_next;
            err_reg   <= err_next;
            neg_reg   <= neg_next;
        end
    end

endmodule

// ===== src/drae_out_fifo.sv =====
// Four-entry result queue that takes up to two results per cycle.
`timescale 1ns / 1ps
module drae_out_fifo (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push_a,
    input  drae_pkg::result_t data_a,
    input  logic              push_b,
    input  drae_pkg::result_t data_b,
    output logic              full2,
    output logic              out_valid,
    input  logic              out_stall,
    output drae_pkg::result_t out_data
);
    import drae_pkg::*;

    result_t    mem [4];
    logic [1:0] head_reg, head_next;
    logic [1:0] tail_reg, tail_next;
    logic [2:0] count_reg, count_next;
    logic       pop;
    logic [1:0] tail_b;

    assign out_valid = (count_reg != 3'd0);
    assign out_data  = mem[head_reg];
    assign full2     = (count_reg > 3'd2);
    assign pop       = out_valid && !out_stall;
    assign tail_b    = push_a ? tail_reg + 2'd1 : tail_reg;

    always_comb
    begin
        head_next  = pop ? head_reg + 2'd1 : head_reg;
        tail_next  = tail_reg + 2'(push_a) + 2'(push_b);
        count_next = count_reg + 3'(push_a) + 3'(push_b) - 3'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push_a)
            mem[tail_reg] <= data_a;
        if (push_b)
            mem[tail_b] <= data_b;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

endmodule
